FILE: design/tbn_pkg.sv
// ----------------------------------------------------------------------------
// Triangle box and normal: shared constants
// Default widths and the fixed widths of the normalized cross-product path.
// ----------------------------------------------------------------------------
package tbn_pkg;

   localparam int COORD_BITS_DEF  = 24;
   localparam int NORMAL_FRAC_DEF = 14;

   // Normalized cross-product magnitudes carry their top bit at bit 29.
   localparam int M_BITS      = 30;
   localparam int RAD_BITS    = 2 * M_BITS + 2;
   localparam int ROOT_BITS   = RAD_BITS / 2;
   localparam int SQRT_STAGES = ROOT_BITS;

endpackage

FILE: design/tbn_isqrt.sv
// ----------------------------------------------------------------------------
// Triangle box and normal: pipelined integer square root
// Floor square root of the sum of squares, one root bit per register stage.
// ----------------------------------------------------------------------------
module tbn_isqrt (
   input  logic                           clock,
   input  logic                           ce,
   input  logic [tbn_pkg::RAD_BITS-1:0]   rad,
   output logic [tbn_pkg::ROOT_BITS-1:0]  root
);

   localparam int RAD_W  = tbn_pkg::RAD_BITS;
   localparam int ROOT_W = tbn_pkg::ROOT_BITS;
   localparam int REM_W  = ROOT_W + 2;
   localparam int ACC_W  = REM_W + 2;
   localparam int STG    = tbn_pkg::SQRT_STAGES;

   logic [RAD_W-1:0]  rad_ff  [STG-1];
   logic [REM_W-1:0]  rem_ff  [STG-1];
   logic [ROOT_W-1:0] root_ff [STG];

   for (genvar k = 0; k < STG; k++) begin : g_stage
      logic [RAD_W-1:0]  rad_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [ACC_W-1:0]  acc;
      logic [ACC_W-1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_src  = rad;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      assign acc     = {rem_src, rad_src[RAD_W-1 -: 2]};
      assign trial   = {2'b00, root_src, 2'b01};
      assign take    = (acc >= trial);
      assign rem_in  = take ? REM_W'(acc - trial) : acc[REM_W-1:0];
      assign root_in = {root_src[ROOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (ce) begin
            root_ff[k] <= root_in;
         end
      end

      if (k < STG - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (ce) begin
               rad_ff[k] <= rad_src << 2;
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign root = root_ff[STG-1];

endmodule

FILE: design/tbn_div.sv
// ----------------------------------------------------------------------------
// Triangle box and normal: pipelined rounding divider
// Computes (m * 2^FRAC_BITS + den / 2) / den with one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbn_div #(
   parameter int FRAC_BITS = tbn_pkg::NORMAL_FRAC_DEF
) (
   input  logic                           clock,
   input  logic                           ce,
   input  logic [tbn_pkg::M_BITS-1:0]     num_m,
   input  logic [tbn_pkg::ROOT_BITS-1:0]  den,
   output logic [FRAC_BITS:0]             quot
);

   localparam int D_W   = tbn_pkg::ROOT_BITS;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int NUM_W = tbn_pkg::M_BITS + Q_W;

   logic [NUM_W-1:0] num_ff;
   logic [D_W-1:0]   den0_ff;
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [D_W-1:0]   rem_ff [Q_W-1];
   logic [Q_W-1:0]   lo_ff  [Q_W-1];
   logic [D_W-1:0]   den_ff [Q_W-1];

   always_ff @(posedge clock) begin
      if (ce) begin
         num_ff  <= (NUM_W'(num_m) << FRAC_BITS) + NUM_W'(den >> 1);
         den0_ff <= den;
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic [D_W-1:0] rem_src;
      logic [Q_W-1:0] lo_src;
      logic [Q_W-1:0] q_src;
      logic [D_W-1:0] den_src;
      logic [D_W:0]   acc;
      logic [D_W:0]   dext;
      logic           take;
      logic [D_W-1:0] rem_in;

      if (j == 0) begin : g_first
         assign rem_src = D_W'(num_ff[NUM_W-1:Q_W]);
         assign lo_src  = num_ff[Q_W-1:0];
         assign q_src   = '0;
         assign den_src = den0_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign lo_src  = lo_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign den_src = den_ff[j-1];
      end

      assign acc    = {rem_src, lo_src[Q_W-1]};
      assign dext   = {1'b0, den_src};
      assign take   = (acc >= dext);
      assign rem_in = take ? D_W'(acc - dext) : acc[D_W-1:0];

      always_ff @(posedge clock) begin
         if (ce) begin
            q_ff[j] <= {q_src[Q_W-2:0], take};
         end
      end

      if (j < Q_W - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (ce) begin
               rem_ff[j] <= rem_in;
               lo_ff[j]  <= lo_src << 1;
               den_ff[j] <= den_src;
            end
         end
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

FILE: design/triangle_bbox_and_normal.sv
// ----------------------------------------------------------------------------
// Triangle bounding box and unit normal
// Per-axis box of three vertices and the rounded unit normal of the triangle.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Contents
//  req      in         req_tvalid/tready     nine vertex coordinates
//  rsp      out        rsp_tvalid/tready     box, unit normal, degenerate flag
//  csr      in         csr_we                compute_normals enable
//
//  One triangle enters per cycle unless the pipeline holds; each passes
//  from acceptance to its result through, among others, the 31 root stages
//  and the NORMAL_FRAC_BITS + 1 quotient stages. Reset clears all valid bits
//  and turns normal computation on. When a result waits on rsp_tready the
//  whole pipeline holds and req_tready falls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module triangle_bbox_and_normal #(
   parameter int COORD_BITS       = tbn_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = tbn_pkg::NORMAL_FRAC_DEF,
   localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((6 * COORD_BITS + 3 * (NORMAL_FRAC_BITS + 2) + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // min_x, min_y, min_z, max_x, max_y, max_z, normal_x, normal_y, normal_z
   output logic [OUT_W-1:0] rsp_tdata,
   // degenerate
   output logic             rsp_tuser
);

   localparam int M_W     = tbn_pkg::M_BITS;
   localparam int RAD_W   = tbn_pkg::RAD_BITS;
   localparam int ROOT_W  = tbn_pkg::ROOT_BITS;
   localparam int EDGE_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W   = (CROSS_W > M_W + 1) ? CROSS_W : M_W + 1;
   localparam int LEN_W   = $clog2(MAG_W + 1);
   localparam int SQ_W    = 2 * M_W;
   localparam int Q_W     = NORMAL_FRAC_BITS + 1;
   localparam int NB      = NORMAL_FRAC_BITS + 2;
   localparam int ROOT_AT = 8 + tbn_pkg::SQRT_STAGES;
   localparam int LAT     = ROOT_AT + 1 + Q_W + 1;

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] hi;
      logic [2:0][COORD_BITS-1:0] lo;
      logic                       en;
   } side_type;

   logic                             adv;
   logic [LAT:1]                     vld_ff;
   logic                             en_ff;

   logic signed [COORD_BITS-1:0]     coord [9];
   side_type                         side_in;
   logic signed [EDGE_W-1:0]         e1_in [3];
   logic signed [EDGE_W-1:0]         e2_in [3];

   logic signed [EDGE_W-1:0]         e1_ff [3];
   logic signed [EDGE_W-1:0]         e2_ff [3];
   logic signed [PROD_W-1:0]         prod_ff [6];
   logic signed [CROSS_W-1:0]        cross_ff [3];
   logic signed [MAG_W-1:0]          cext [3];
   logic [MAG_W-1:0]                 mag4_ff [3];
   logic [MAG_W-1:0]                 mag5_ff [3];
   logic [MAG_W-1:0]                 or_v;
   logic [LEN_W-1:0]                 len_in;
   logic [LEN_W-1:0]                 len_ff;
   logic [LEN_W-1:0]                 sh;
   logic [MAG_W-1:0]                 sft [3];
   logic [2:0][M_W-1:0]              m_in;
   logic [SQ_W-1:0]                  sq_ff [3];
   logic [RAD_W-1:0]                 rad_ff;
   logic [ROOT_W-1:0]                root;
   logic [Q_W-1:0]                   quot [3];

   side_type                         side_ff [1:LAT-1];
   logic [2:0]                       neg_ff  [4:LAT-1];
   logic                             zero_ff [5:LAT-1];
   logic [2:0][M_W-1:0]              m_ff    [6:ROOT_AT];

   logic [2:0][NB-1:0]               nrm_in;
   logic                             deg_in;
   logic [OUT_W-1:0]                 data_ff;
   logic                             user_ff;

   assign adv        = !vld_ff[LAT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         en_ff  <= 1'b1;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-1:1], req_tvalid};
         end
         if (csr_we) begin
            en_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         coord[k] = signed'(req_tdata[k*COORD_BITS +: COORD_BITS]);
      end
      side_in.en = en_ff;
      for (int i = 0; i < 3; i++) begin
         side_in.lo[i] = coord[i];
         side_in.hi[i] = coord[i];
         if (coord[3+i] < signed'(side_in.lo[i])) side_in.lo[i] = coord[3+i];
         if (coord[3+i] > signed'(side_in.hi[i])) side_in.hi[i] = coord[3+i];
         if (coord[6+i] < signed'(side_in.lo[i])) side_in.lo[i] = coord[6+i];
         if (coord[6+i] > signed'(side_in.hi[i])) side_in.hi[i] = coord[6+i];
         e1_in[i] = EDGE_W'(coord[3+i]) - EDGE_W'(coord[i]);
         e2_in[i] = EDGE_W'(coord[6+i]) - EDGE_W'(coord[i]);
      end
   end

   always_comb begin
      or_v = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      for (int i = 0; i < 3; i++) begin
         cext[i] = MAG_W'(cross_ff[i]);
      end
   end

   always_comb begin
      len_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (or_v[b]) len_in = LEN_W'(b + 1);
      end
   end

   always_comb begin
      sh = LEN_W'(MAG_W) - len_ff;
      for (int i = 0; i < 3; i++) begin
         sft[i]  = mag5_ff[i] << sh;
         m_in[i] = sft[i][MAG_W-1 -: M_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= e1_in[i];
            e2_ff[i] <= e2_in[i];
         end
         prod_ff[0] <= PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[2]);
         prod_ff[1] <= PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[1]);
         prod_ff[2] <= PROD_W'(e1_ff[2]) * PROD_W'(e2_ff[0]);
         prod_ff[3] <= PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[2]);
         prod_ff[4] <= PROD_W'(e1_ff[0]) * PROD_W'(e2_ff[1]);
         prod_ff[5] <= PROD_W'(e1_ff[1]) * PROD_W'(e2_ff[0]);
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= CROSS_W'(prod_ff[2*i]) - CROSS_W'(prod_ff[2*i+1]);
            mag4_ff[i]  <= cross_ff[i][CROSS_W-1] ? MAG_W'(-cext[i]) : MAG_W'(cext[i]);
            mag5_ff[i]  <= mag4_ff[i];
            sq_ff[i]    <= SQ_W'(m_ff[6][i]) * SQ_W'(m_ff[6][i]);
         end
         len_ff <= len_in;
         rad_ff <= RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);

         side_ff[1] <= side_in;
         for (int k = 2; k < LAT; k++) side_ff[k] <= side_ff[k-1];
         neg_ff[4] <= {cross_ff[2][CROSS_W-1], cross_ff[1][CROSS_W-1],
                       cross_ff[0][CROSS_W-1]};
         for (int k = 5; k < LAT; k++) neg_ff[k] <= neg_ff[k-1];
         zero_ff[5] <= (len_in == '0);
         for (int k = 6; k < LAT; k++) zero_ff[k] <= zero_ff[k-1];
         m_ff[6] <= m_in;
         for (int k = 7; k <= ROOT_AT; k++) m_ff[k] <= m_ff[k-1];

         data_ff <= OUT_W'({nrm_in, side_ff[LAT-1].hi, side_ff[LAT-1].lo});
         user_ff <= deg_in;
      end
   end

   tbn_isqrt u_isqrt (
      .clock (clock),
      .ce    (adv),
      .rad   (rad_ff),
      .root  (root)
   );

   for (genvar i = 0; i < 3; i++) begin : g_div
      tbn_div #(
         .FRAC_BITS (NORMAL_FRAC_BITS)
      ) u_div (
         .clock (clock),
         .ce    (adv),
         .num_m (m_ff[ROOT_AT][i]),
         .den   (root),
         .quot  (quot[i])
      );
   end

   always_comb begin
      deg_in = side_ff[LAT-1].en && zero_ff[LAT-1];
      for (int i = 0; i < 3; i++) begin
         if (!side_ff[LAT-1].en || zero_ff[LAT-1]) begin
            nrm_in[i] = '0;
         end else if (neg_ff[LAT-1][i]) begin
            nrm_in[i] = -NB'(quot[i]);
         end else begin
            nrm_in[i] = NB'(quot[i]);
         end
      end
   end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Triangle box and normal regression
// Drives triangles with random bursts and gaps against a stalling receiver,
// predicts each bounding box and rounded unit normal in exact integer
// arithmetic, and checks every result in order across settings of the
// normal-enable register.
// ----------------------------------------------------------------------------
class bbox_normal_board;
   typedef struct {
      logic [23:0] lo [3];
      logic [23:0] hi [3];
      logic [15:0] nrm [3];
      logic        degen;
   } box_result_type;

   box_result_type pending [$];
   bit          normals_on = 1'b1;
   int          errors = 0;

   function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void note_triangle(logic [215:0] data);
      box_result_type     res;
      logic signed [63:0] v [9];
      logic signed [63:0] e1 [3];
      logic signed [63:0] e2 [3];
      logic signed [127:0] cr [3];
      logic [127:0]       mag [3];
      logic [63:0]        m [3];
      logic [63:0]        s;
      logic [63:0]        root;
      logic [63:0]        q;
      int                 len;
      int                 l;
      for (int i = 0; i < 9; i++) v[i] = $signed(data[24*i +: 24]);
      for (int i = 0; i < 3; i++) begin
         logic signed [63:0] mn;
         logic signed [63:0] mx;
         mn = v[i];
         mx = v[i];
         if (v[3+i] < mn) mn = v[3+i];
         if (v[3+i] > mx) mx = v[3+i];
         if (v[6+i] < mn) mn = v[6+i];
         if (v[6+i] > mx) mx = v[6+i];
         res.lo[i] = mn[23:0];
         res.hi[i] = mx[23:0];
         res.nrm[i] = 0;
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
      end
      res.degen = 0;
      if (normals_on) begin
         cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
         cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
         cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
         len = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? 128'(-cr[i]) : 128'(cr[i]);
            l = 0;
            for (int k = 0; k < 128; k++) if (mag[i][k]) l = k + 1;
            if (l > len) len = l;
         end
         if (len == 0) begin
            res.degen = 1;
         end else begin
            s = 0;
            for (int i = 0; i < 3; i++) begin
               if (len > 30) m[i] = 64'(mag[i] >> (len - 30));
               else m[i] = 64'(mag[i] << (30 - len));
               s = s + m[i] * m[i];
            end
            root = root64(s);
            for (int i = 0; i < 3; i++) begin
               q = ((m[i] << 14) + (root >> 1)) / root;
               res.nrm[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
            end
         end
      end
      pending.insert(pending.size(), res);
   endfunction

   function void check_result(logic [191:0] data, logic degen);
      box_result_type exp;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, data);
         errors++;
         return;
      end
      exp = pending.pop_front();
      for (int i = 0; i < 3; i++) begin
         if (data[24*i +: 24] !== exp.lo[i]) begin
            $display("%0t: min[%0d] expected %h actual %h", $time, i, exp.lo[i],
                     data[24*i +: 24]);
            errors++;
         end
         if (data[72+24*i +: 24] !== exp.hi[i]) begin
            $display("%0t: max[%0d] expected %h actual %h", $time, i, exp.hi[i],
                     data[72+24*i +: 24]);
            errors++;
         end
         if (data[144+16*i +: 16] !== exp.nrm[i]) begin
            $display("%0t: normal[%0d] expected %h actual %h", $time, i, exp.nrm[i],
                     data[144+16*i +: 16]);
            errors++;
         end
      end
      if (degen !== exp.degen) begin
         $display("%0t: degenerate expected %b actual %b", $time, exp.degen, degen);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int PIPE_DEPTH = 56;
   localparam int IDLE_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_we = 0;
   logic         csr_wdata = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [215:0] req_tdata = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic         rsp_tuser;

   bbox_normal_board board = new();
   int   idle_cycles = 0;
   bit   stall_mode = 0;

   triangle_bbox_and_normal dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_triangle(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("triangle_bbox_and_normal regression: fail");
            $finish;
         end
      end
   end

   // Receiver alternates between long free-flowing and heavily stalled stretches.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      if (stall_mode) rsp_tready <= ($urandom_range(0, 3) == 0);
      else rsp_tready <= ($urandom_range(0, 9) != 0);
   end

   function automatic logic [23:0] rand_coord(int kind);
      case (kind)
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         default: return 24'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   task automatic send_triangle(logic [215:0] data);
      req_tvalid <= 1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_gap();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_normals(bit on);
      csr_we <= 1;
      csr_wdata <= on;
      @(posedge clock);
      csr_we <= 0;
      board.normals_on = on;
   endtask

   task automatic random_phase(int count);
      logic [215:0] d;
      int           kind;
      int           burst;
      int           sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && sent < count; b++) begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) d[24*i +: 24] = rand_coord(kind);
            case ($urandom_range(0, 9))
               0: d[72 +: 72] = d[0 +: 72];
               1: d[144 +: 72] = d[0 +: 72];
               2: d[144 +: 72] = d[72 +: 72];
               default: ;
            endcase
            send_triangle(d);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) send_gap();
      end
   endtask

   task automatic directed_phase();
      logic [215:0] d;
      d = 0;
      send_triangle(d);
      d = {9{24'h7fffff}};
      send_triangle(d);
      d = {9{24'h800000}};
      send_triangle(d);
      d = {24'h0, 24'h001000, 24'h0, 24'h0, 24'h0, 24'h001000, 24'h0, 24'h0, 24'h0};
      send_triangle(d);
      d = {24'h001000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h001000, 24'h0, 24'h0, 24'h0};
      send_triangle(d);
      d = {24'h0, 24'h0, 24'h001000, 24'h0, 24'h001000, 24'h0, 24'h0, 24'h0, 24'h0};
      send_triangle(d);
      d = {24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
           24'h7fffff, 24'h7fffff, 24'h800000};
      send_triangle(d);
      d = {24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff,
           24'h800000, 24'h800000, 24'h7fffff};
      send_triangle(d);
      d = {24'h000003, 24'h000003, 24'h000003, 24'h000002, 24'h000002, 24'h000002,
           24'h000001, 24'h000001, 24'h000001};
      send_triangle(d);
      d = {24'h000001, 24'h0, 24'h0, 24'h0, 24'h000001, 24'h0, 24'h0, 24'h0, 24'h0};
      send_triangle(d);
      d = {24'hfffffe, 24'h7fffff, 24'h000001, 24'h800000, 24'h000001, 24'hffffff,
           24'h123456, 24'h800001, 24'h000002};
      send_triangle(d);
      req_tvalid <= 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_phase();
      random_phase(300);
      drain();
      write_normals(0);
      directed_phase();
      random_phase(150);
      drain();
      write_normals(1);
      random_phase(350);
      drain();
      write_normals(0);
      random_phase(100);
      drain();
      write_normals(1);
      directed_phase();
      random_phase(150);
      drain();
      if (board.errors == 0) begin
         $display("triangle_bbox_and_normal regression: pass");
      end else begin
         $display("triangle_bbox_and_normal regression: fail");
      end
      $finish;
   end
endmodule

FILE: files.f
design/tbn_pkg.sv
design/tbn_isqrt.sv
design/tbn_div.sv
design/triangle_bbox_and_normal.sv
test/testbench.sv
